// ===== src/dial_combination_lock_assert.svh =====
// Assertion macros shared by the dial lock RTL.
// Clock clk_i and active-low reset rst_ni must be visible at the point of use.
`ifndef DIAL_COMBINATION_LOCK_ASSERT_SVH
`define DIAL_COMBINATION_LOCK_ASSERT_SVH

// Generic clocked assertion, disabled while in reset.
`define DCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form: antecedent holds -> consequent holds in the same cycle.
`define DCL_ASSERT_IMP(label, ante, cons, msg) \
  `DCL_ASSERT(label, (ante) |-> (cons), msg)

// Implication form: antecedent holds -> consequent holds in the next cycle.
`define DCL_ASSERT_NXT(label, ante, cons, msg) \
  `DCL_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== src/dcl_pkg.sv =====
// ----------------------------------------------------------------------------
// dcl_pkg
// Types and constants shared by the dial combination lock and its search unit.
// ----------------------------------------------------------------------------
package dcl_pkg;

  localparam int unsigned PosW       = 12;
  localparam int unsigned PosCounts  = 4096;
  localparam int unsigned RelW       = PosW + 1;
  localparam int unsigned MaxElems   = 64;
  localparam int unsigned ElemW      = $clog2(MaxElems);
  localparam int unsigned CntW       = ElemW + 1;
  localparam int unsigned AngW       = PosW + CntW - 1;
  localparam int unsigned CodeLen    = 4;
  localparam int unsigned CodeW      = 6;
  localparam int unsigned DigitW     = 7;
  localparam int unsigned DigIdxW    = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned PhaseW     = 3;

  localparam logic [DigitW-1:0] UndefDigit = 7'd64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCodeFirst  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeSecond = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCodeThird  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCodeFourth = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgElemStep   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSnapTol    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDialElems  = 3'd6;

  // phase codes as seen on the result
  localparam logic [PhaseW-1:0] PhCodeInit    = 3'd0;
  localparam logic [PhaseW-1:0] PhCodeEnter   = 3'd1;
  localparam logic [PhaseW-1:0] PhCodeCheck   = 3'd2;
  localparam logic [PhaseW-1:0] PhCodeCorrect = 3'd3;
  localparam logic [PhaseW-1:0] PhCodeWrong   = 3'd4;

  typedef enum logic [4:0] {
    PH_INIT    = 5'b00001,
    PH_ENTER   = 5'b00010,
    PH_CHECK   = 5'b00100,
    PH_CORRECT = 5'b01000,
    PH_WRONG   = 5'b10000
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_UPDATE = 4'b1000
  } seq_state_e;

  // search unit status toward the sequencer
  typedef struct packed {
    logic             done;
    logic             found;
    logic [ElemW-1:0] index;
  } srch_res_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] c;
    c = PhCodeInit;
    unique case (ph)
      PH_INIT:    c = PhCodeInit;
      PH_ENTER:   c = PhCodeEnter;
      PH_CHECK:   c = PhCodeCheck;
      PH_CORRECT: c = PhCodeCorrect;
      PH_WRONG:   c = PhCodeWrong;
      default:    c = PhCodeInit;
    endcase
    return c;
  endfunction

endpackage

// ===== src/dcl_search.sv =====
// ----------------------------------------------------------------------------
// dcl_search
// Walks the dial elements one per cycle and reports the first one whose angle
// lies strictly within the tolerance of the relative position.
// ----------------------------------------------------------------------------
module dcl_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dcl_pkg::RelW-1:0]   rel_i,
  input  logic [dcl_pkg::CntW-1:0]   n_i,
  input  logic [dcl_pkg::PosW-1:0]   step_i,
  input  logic [dcl_pkg::PosW-1:0]   tol_i,
  output dcl_pkg::srch_res_t         res_o
);
  import dcl_pkg::*;

  localparam int unsigned DiffW = AngW + 2;

  logic                busy_q, busy_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [AngW-1:0]     ang_q, ang_d;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]    mag;
  logic                in_range, hit, done;

  // signed distance between position and the current element angle
  assign diff = $signed({{(DiffW-RelW){1'b0}}, rel_i}) - $signed({2'b00, ang_q});
  assign mag  = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign in_range = idx_q < n_i;
  assign hit  = in_range && (mag < {{(DiffW-PosW){1'b0}}, tol_i});
  assign done = busy_q && (hit || !in_range);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    ang_d  = ang_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      ang_d  = '0;
    end else if (busy_q) begin
      if (done) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + CntW'(1);
        ang_d = ang_q + {{(AngW-PosW){1'b0}}, step_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ang_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ang_q  <= ang_d;
    end
  end

  assign res_o.done  = done;
  assign res_o.found = busy_q && hit;
  assign res_o.index = idx_q[ElemW-1:0];

`include "dial_combination_lock_assert.svh"

  `DCL_ASSERT_IMP(a_found_in_range, res_o.found, idx_q < n_i, "search hit beyond element count")
  `DCL_ASSERT_IMP(a_no_restart_busy, start_i, !busy_q, "search restarted while busy")
  `DCL_ASSERT_NXT(a_done_ends_busy, done && !start_i, !busy_q, "search kept running after done")

endmodule

// ===== src/dial_combination_lock.sv =====
// ----------------------------------------------------------------------------
// dial_combination_lock: one result per tick or restart; reset clears all state, no clear pass.
// Each item passes ST_LOAD, then the element search on an enter tick, then ST_UPDATE;
// the search checks one candidate per cycle, min(dial_elements, 64) of them on a miss.
// Items enter only in ST_IDLE, after the prior result issues; ST_UPDATE stalls while one waits.
// ----------------------------------------------------------------------------
module dial_combination_lock (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [dcl_pkg::PosW-1:0]      dial_position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dcl_pkg::PhaseW-1:0]    phase_o,
  output logic [dcl_pkg::DigitW-1:0]    entered_first_o,
  output logic [dcl_pkg::DigitW-1:0]    entered_second_o,
  output logic [dcl_pkg::DigitW-1:0]    entered_third_o,
  output logic [dcl_pkg::DigitW-1:0]    entered_fourth_o,
  output logic                          open_pulse_o,
  output logic                          wrong_pulse_o,
  output logic [dcl_pkg::DigIdxW-1:0]   digit_position_o,
  input  logic                          cfg_we_i,
  input  logic [dcl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dcl_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dcl_pkg::*;

  // configuration
  logic [CodeW-1:0]  code_q [CodeLen];
  logic [PosW-1:0]   step_q, tol_q;
  logic [CntW-1:0]   elems_q;

  // sequencer and lock state
  seq_state_e        state_q, state_d;
  phase_e            phase_q, phase_d;
  logic              kind_q, kind_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              first_q, first_d;
  logic [DigitW-1:0] entered_q [CodeLen];
  logic [DigitW-1:0] entered_d [CodeLen];
  logic [DigIdxW-1:0] digit_q, digit_d;
  logic [ElemW-1:0]  last_q, last_d;
  logic [ElemW-1:0]  cur_q, cur_d;
  logic              ccw_q, ccw_d;
  logic [PosW-1:0]   null_q, null_d;
  logic [RelW-1:0]   rel_q, rel_d;
  logic [CntW-1:0]   n_q, n_d;
  logic              open_q, open_d;
  logic              wrong_q, wrong_d;
  logic              out_valid_q, out_valid_d;

  logic              srch_start;
  srch_res_t         srch_res;
  logic [PosW-1:0]   rel_cw;
  logic              rising, falling, code_ok, can_finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CodeLen; k++) code_q[k] <= '0;
      step_q  <= 12'd102;
      tol_q   <= 12'd20;
      elems_q <= 7'd40;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCodeFirst:  code_q[0] <= cfg_data_i[CodeW-1:0];
        CfgCodeSecond: code_q[1] <= cfg_data_i[CodeW-1:0];
        CfgCodeThird:  code_q[2] <= cfg_data_i[CodeW-1:0];
        CfgCodeFourth: code_q[3] <= cfg_data_i[CodeW-1:0];
        CfgElemStep:   step_q    <= cfg_data_i[PosW-1:0];
        CfgSnapTol:    tol_q     <= cfg_data_i[PosW-1:0];
        CfgDialElems:  elems_q   <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  dcl_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .rel_i   (rel_q),
    .n_i     (n_q),
    .step_i  (step_q),
    .tol_i   (tol_q),
    .res_o   (srch_res)
  );

  assign rel_cw     = pos_q - null_q;
  assign can_finish = !out_valid_q || out_ready_i;
  assign rising  = (cur_q > last_q) ||
                   ((cur_q == '0) && (n_q != '0) && ({1'b0, last_q} == n_q - CntW'(1)));
  assign falling = cur_q < last_q;

  always_comb begin
    code_ok = 1'b1;
    for (int k = 0; k < CodeLen; k++) begin
      if (entered_q[k] != {1'b0, code_q[k]}) code_ok = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    first_d     = first_q;
    entered_d   = entered_q;
    digit_d     = digit_q;
    last_d      = last_q;
    cur_d       = cur_q;
    ccw_d       = ccw_q;
    null_d      = null_q;
    rel_d       = rel_q;
    n_d         = n_q;
    open_d      = open_q;
    wrong_d     = wrong_q;
    out_valid_d = out_valid_q && !out_ready_i;
    srch_start  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          pos_d   = dial_position_i;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!kind_q && (phase_q == PH_ENTER)) begin
          if (first_q) begin
            first_d = 1'b0;
            cur_d   = '0;
            last_d  = '0;
          end
          // mirrored zero stays at a full turn
          rel_d = ccw_q ? RelW'(PosCounts) - {1'b0, rel_cw} : {1'b0, rel_cw};
          n_d   = (elems_q > CntW'(MaxElems)) ? CntW'(MaxElems) : elems_q;
          srch_start = 1'b1;
          state_d    = ST_SEARCH;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_SEARCH: begin
        if (srch_res.done) begin
          if (srch_res.found) cur_d = srch_res.index;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (can_finish) begin
          out_valid_d = 1'b1;
          open_d      = 1'b0;
          wrong_d     = 1'b0;
          state_d     = ST_IDLE;
          if (kind_q) begin
            phase_d = PH_INIT;
            first_d = 1'b1;
          end else begin
            unique case (phase_q)
              PH_INIT: begin
                for (int k = 0; k < CodeLen; k++) entered_d[k] = UndefDigit;
                ccw_d   = 1'b1;
                null_d  = pos_q;
                phase_d = PH_ENTER;
                first_d = 1'b1;
              end
              PH_ENTER: begin
                if (rising) begin
                  last_d = cur_q;
                  entered_d[digit_q] = {1'b0, cur_q};
                end else if (falling) begin
                  last_d = cur_q;
                  if (digit_q == DigIdxW'(CodeLen - 1)) begin
                    phase_d = PH_CHECK;
                    first_d = 1'b1;
                    digit_d = '0;
                  end else begin
                    ccw_d   = !ccw_q;
                    null_d  = pos_q;
                    last_d  = '0;
                    cur_d   = '0;
                    digit_d = digit_q + DigIdxW'(1);
                  end
                end
              end
              PH_CHECK: begin
                phase_d = code_ok ? PH_CORRECT : PH_WRONG;
                first_d = 1'b1;
              end
              PH_CORRECT: begin
                open_d  = 1'b1;
                phase_d = PH_INIT;
                first_d = 1'b1;
              end
              PH_WRONG: begin
                wrong_d = 1'b1;
                phase_d = PH_INIT;
                first_d = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_INIT;
      kind_q      <= 1'b0;
      pos_q       <= '0;
      first_q     <= 1'b1;
      for (int k = 0; k < CodeLen; k++) entered_q[k] <= UndefDigit;
      digit_q     <= '0;
      last_q      <= '0;
      cur_q       <= '0;
      ccw_q       <= 1'b1;
      null_q      <= '0;
      rel_q       <= '0;
      n_q         <= '0;
      open_q      <= 1'b0;
      wrong_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      entered_q   <= entered_d;
      digit_q     <= digit_d;
      last_q      <= last_d;
      cur_q       <= cur_d;
      ccw_q       <= ccw_d;
      null_q      <= null_d;
      rel_q       <= rel_d;
      n_q         <= n_d;
      open_q      <= open_d;
      wrong_q     <= wrong_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o       = state_q == ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign phase_o          = phase_code(phase_q);
  assign entered_first_o  = entered_q[0];
  assign entered_second_o = entered_q[1];
  assign entered_third_o  = entered_q[2];
  assign entered_fourth_o = entered_q[3];
  assign open_pulse_o     = open_q;
  assign wrong_pulse_o    = wrong_q;
  assign digit_position_o = digit_q;

`include "dial_combination_lock_assert.svh"

  `DCL_ASSERT(a_pulses_exclusive, !(open_q && wrong_q), "open and wrong pulse together")
  `DCL_ASSERT_IMP(a_digit_on_update, !$stable(digit_q), $past(state_q == ST_UPDATE), "bad digit step")
  `DCL_ASSERT_NXT(a_transfer_loads, in_valid_i && in_ready_o, state_q == ST_LOAD, "item not loaded")
  `DCL_ASSERT_IMP(a_phase_on_update, !$stable(phase_q), $past(state_q == ST_UPDATE), "bad phase step")

endmodule

// ===== test/tb_dial_combination_lock.sv =====
// ----------------------------------------------------------------------------
// tb_dial_combination_lock
// Self-checking bench for the dial combination lock. A cycle-free model of
// the phase machine and element search predicts every result. Stimulus is a
// directed walk through opening, wrap-around, restart and undefined digits,
// then random combination entries and stray ticks over several geometries,
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_dial_combination_lock;
  import dcl_pkg::*;

  localparam int SettleCycles = 80;

  typedef struct packed {
    logic [PhaseW-1:0]                  phase;
    logic [CodeLen-1:0][DigitW-1:0]     digit;
    logic                               open_p;
    logic                               wrong_p;
    logic [DigIdxW-1:0]                 digit_idx;
  } lock_view_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                kind_i = 1'b0;
  logic [PosW-1:0]     dial_position_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [PhaseW-1:0]   phase_o;
  logic [DigitW-1:0]   entered_first_o;
  logic [DigitW-1:0]   entered_second_o;
  logic [DigitW-1:0]   entered_third_o;
  logic [DigitW-1:0]   entered_fourth_o;
  logic                open_pulse_o;
  logic                wrong_pulse_o;
  logic [DigIdxW-1:0]  digit_position_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // lock model: configuration
  logic [CodeW-1:0]    code_q [CodeLen] = '{default: '0};
  logic [PosW-1:0]     step_q = 12'd102;
  logic [PosW-1:0]     tol_q = 12'd20;
  logic [6:0]          elems_q = 7'd40;
  // lock model: state
  logic [PhaseW-1:0]   ph_q = PhCodeInit;
  logic                first_q = 1'b1;
  logic [DigitW-1:0]   dig_q [CodeLen] = '{default: UndefDigit};
  logic [DigIdxW-1:0]  idx_q = '0;
  logic [ElemW-1:0]    last_q = '0;
  logic [ElemW-1:0]    cur_q = '0;
  logic                ccw_q = 1'b1;
  logic [PosW-1:0]     null_q = '0;

  lock_view_t pending_views [$];
  int mismatches = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  dial_combination_lock dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .dial_position_i  (dial_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .phase_o          (phase_o),
    .entered_first_o  (entered_first_o),
    .entered_second_o (entered_second_o),
    .entered_third_o  (entered_third_o),
    .entered_fourth_o (entered_fourth_o),
    .open_pulse_o     (open_pulse_o),
    .wrong_pulse_o    (wrong_pulse_o),
    .digit_position_o (digit_position_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int live_elems();
    return (elems_q > MaxElems) ? int'(MaxElems) : int'(elems_q);
  endfunction

  // Advances the lock model by one tick or restart and returns the result.
  function automatic lock_view_t lock_advance(logic kind, logic [PosW-1:0] pos);
    lock_view_t v;
    logic [PosW-1:0] delta;
    int rel, ang, tol, n, i, k;
    logic hit, ok;
    v.open_p = 1'b0;
    v.wrong_p = 1'b0;
    if (kind) begin
      ph_q = PhCodeInit;
      first_q = 1'b1;
    end else begin
      case (ph_q)
        PhCodeInit: begin
          for (k = 0; k < CodeLen; k++) dig_q[k] = UndefDigit;
          ccw_q = 1'b1;
          null_q = pos;
          ph_q = PhCodeEnter;
          first_q = 1'b1;
        end
        PhCodeEnter: begin
          if (first_q) begin
            first_q = 1'b0;
            cur_q = '0;
            last_q = '0;
          end
          delta = pos - null_q;
          rel = int'(delta);
          // counter-clockwise mirrors; zero becomes a full turn, not wrapped
          if (ccw_q) rel = int'(PosCounts) - rel;
          n = live_elems();
          tol = int'(tol_q);
          hit = 1'b0;
          for (i = 0; i < n && !hit; i++) begin
            ang = int'(step_q) * i;
            if (rel < ang + tol && rel > ang - tol) begin
              cur_q = ElemW'(i);
              hit = 1'b1;
            end
          end
          if (cur_q > last_q || (cur_q == 0 && n >= 1 && int'(last_q) == n - 1)) begin
            last_q = cur_q;
            dig_q[idx_q] = {1'b0, cur_q};
          end else if (cur_q < last_q) begin
            last_q = cur_q;
            if (idx_q >= CodeLen - 1) begin
              ph_q = PhCodeCheck;
              first_q = 1'b1;
              idx_q = '0;
            end else begin
              ccw_q = ~ccw_q;
              null_q = pos;
              last_q = '0;
              cur_q = '0;
              idx_q = idx_q + 1'b1;
            end
          end
        end
        PhCodeCheck: begin
          ok = 1'b1;
          for (k = 0; k < CodeLen; k++)
            if (dig_q[k] != {1'b0, code_q[k]}) ok = 1'b0;
          ph_q = ok ? PhCodeCorrect : PhCodeWrong;
          first_q = 1'b1;
        end
        PhCodeCorrect: begin
          v.open_p = 1'b1;
          ph_q = PhCodeInit;
          first_q = 1'b1;
        end
        PhCodeWrong: begin
          v.wrong_p = 1'b1;
          ph_q = PhCodeInit;
          first_q = 1'b1;
        end
        default: ;
      endcase
    end
    v.phase = ph_q;
    for (k = 0; k < CodeLen; k++) v.digit[k] = dig_q[k];
    v.digit_idx = idx_q;
    return v;
  endfunction

  function automatic void field_chk(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result side: random stalls, compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    lock_view_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result, phase expected none actual %0d", $time, phase_o);
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        field_chk("phase", want.phase, phase_o);
        field_chk("entered_first", want.digit[0], entered_first_o);
        field_chk("entered_second", want.digit[1], entered_second_o);
        field_chk("entered_third", want.digit[2], entered_third_o);
        field_chk("entered_fourth", want.digit[3], entered_fourth_o);
        field_chk("open_pulse", want.open_p, open_pulse_o);
        field_chk("wrong_pulse", want.wrong_p, wrong_pulse_o);
        field_chk("digit_position", want.digit_idx, digit_position_o);
      end
    end
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_item(logic kind, logic [PosW-1:0] pos);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    dial_position_i <= pos;
    pending_views.push_back(lock_advance(kind, pos));
    items_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // absolute position that reads as elem's angle plus jit in the current direction
  function automatic logic [PosW-1:0] angle_pos(int elem, int jit);
    int a, p;
    a = int'(step_q) * elem + jit;
    p = ccw_q ? int'(null_q) - a : int'(null_q) + a;
    return PosW'(p);
  endfunction

  task automatic dial_to(int elem);
    int jmax, jit;
    jmax = int'(tol_q) - 1;
    if (jmax > int'(step_q) / 2) jmax = int'(step_q) / 2;
    if (jmax < 0) jmax = 0;
    // element 0 only matches from above the null point
    if (elem == 0) jit = (jmax > 0) ? int'($urandom_range(jmax, 1)) : 0;
    else jit = int'($urandom_range(2 * jmax)) - jmax;
    send_item(1'b0, angle_pos(elem, jit));
  endtask

  task automatic drain_lock();
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgCodeFirst:  code_q[0] = val[CodeW-1:0];
      CfgCodeSecond: code_q[1] = val[CodeW-1:0];
      CfgCodeThird:  code_q[2] = val[CodeW-1:0];
      CfgCodeFourth: code_q[3] = val[CodeW-1:0];
      CfgElemStep:   step_q = val;
      CfgSnapTol:    tol_q = val;
      CfgDialElems:  elems_q = val[6:0];
      default: ;
    endcase
  endtask

  task automatic program_lock(logic [CodeLen-1:0][CodeW-1:0] code, logic [PosW-1:0] step,
                              logic [PosW-1:0] tol, logic [6:0] elems);
    drain_lock();
    write_reg(CfgCodeFirst, CfgDataW'(code[0]));
    write_reg(CfgCodeSecond, CfgDataW'(code[1]));
    write_reg(CfgCodeThird, CfgDataW'(code[2]));
    write_reg(CfgCodeFourth, CfgDataW'(code[3]));
    write_reg(CfgElemStep, step);
    write_reg(CfgSnapTol, tol);
    write_reg(CfgDialElems, CfgDataW'(elems));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CodeLen-1:0][CodeW-1:0] random_code(int top);
    logic [CodeLen-1:0][CodeW-1:0] c;
    int k;
    for (k = 0; k < CodeLen; k++) c[k] = CodeW'($urandom_range(top, 1));
    return c;
  endfunction

  task automatic test_directed_walk();
    program_lock({6'd4, 6'd3, 6'd2, 6'd1}, 12'd102, 12'd20, 7'd40);
    // correct entry: 1, 2, 3, 4
    send_item(1'b0, 12'hfff);
    send_item(1'b0, angle_pos(0, 0));  // mirrored zero, nothing matches
    dial_to(1);
    send_item(1'b0, angle_pos(1, 51)); // halfway between elements
    dial_to(0);
    dial_to(2);
    dial_to(0);
    dial_to(3);
    dial_to(1);
    dial_to(4);
    dial_to(2);
    send_item(1'b0, 12'h000);
    send_item(1'b0, 12'h555);
    // wrap-around rise, restart mid-entry, check with undefined digits
    send_item(1'b0, 12'h000);
    dial_to(1);
    dial_to(0);
    dial_to(39);
    dial_to(0);
    send_item(1'b1, 12'haaa);          // keeps the digit index
    send_item(1'b0, 12'h800);
    dial_to(2);
    dial_to(1);
    dial_to(3);
    dial_to(0);
    dial_to(1);
    dial_to(0);
    send_item(1'b0, 12'h3c3);
    send_item(1'b0, 12'hc3c);
  endtask

  // Mostly clean entries of the stored code or random digits, with stray
  // ticks and restarts mixed in.
  task automatic test_code_entry(int budget);
    logic [CodeLen-1:0][CodeW-1:0] dg;
    int stop_at, n, k, guard, tgt, top, pick, up;
    logic use_code;
    stop_at = items_sent + budget;
    n = live_elems();
    while (items_sent < stop_at) begin
      use_code = $urandom_range(1);
      for (k = 0; k < CodeLen; k++)
        if (use_code && code_q[k] != 0 && int'(code_q[k]) < n) dg[k] = code_q[k];
        else dg[k] = CodeW'($urandom_range(n - 1, 1));
      if (ph_q != PhCodeEnter) begin
        if (ph_q != PhCodeInit) send_item(1'b1, PosW'($urandom));
        send_item(1'b0, PosW'($urandom));
      end
      guard = 0;
      while (ph_q == PhCodeEnter && guard < 80) begin
        guard++;
        tgt = int'(dg[idx_q]);
        top = first_q ? 0 : int'(last_q);
        pick = $urandom_range(63);
        if (pick == 0) begin
          send_item(1'b1, PosW'($urandom));
        end else if (pick < 4) begin
          send_item(1'b0, PosW'($urandom));
        end else if (top < tgt) begin
          up = (tgt - top > 3) ? 3 : tgt - top;
          dial_to(top + int'($urandom_range(up, 1)));
        end else begin
          dial_to(int'($urandom_range(tgt - 1, 0)));
        end
      end
      if (ph_q == PhCodeCheck) begin
        send_item(1'b0, PosW'($urandom));
        send_item(1'b0, PosW'($urandom));
      end
    end
  endtask

  task automatic test_stray_ticks(int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(7) == 0) send_item(1'b1, PosW'($urandom));
      else if (live_elems() > 0 && $urandom_range(1))
        dial_to(int'($urandom_range(live_elems() - 1)));
      else send_item(1'b0, PosW'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 24;
    rx_idle_pct = 76;
    test_directed_walk();
    program_lock(random_code(39), 12'd102, 12'd20, 7'd40);
    test_code_entry(260);

    tx_idle_pct = 76;
    rx_idle_pct = 24;
    program_lock({random_code(63)} | {6'd0, 6'd0, 6'd0, 6'd0}, 12'd64, 12'd32, 7'd64);
    program_lock({code_q[3], code_q[2], 6'd1, 6'd63}, 12'd64, 12'd32, 7'd64);
    test_code_entry(220);
    test_stray_ticks(40);
    // more elements than the disk holds
    program_lock(random_code(63), 12'd63, 12'd5, 7'd100);
    test_code_entry(200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_lock({6'd0, 6'd0, 6'd0, 6'd0}, 12'd4095, 12'd4095, 7'd2);
    test_stray_ticks(80);
    program_lock(random_code(63), 12'd1, 12'd0, 7'd0);
    test_stray_ticks(80);
    program_lock(random_code(63), 12'd102, 12'd20, 7'd1);
    test_stray_ticks(60);
    program_lock(random_code(44), 12'd90, 12'd44, 7'd45);
    test_code_entry(300);
    test_stray_ticks(40);

    drain_lock();
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
